[rtl/core/plti_pkg.sv]
`timescale 1ns / 1ps

package plti_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int VAL_W  = 32;
  localparam int IDX_IN_W = 6;
  localparam int PTS_W  = 7;
  localparam int SEG_W  = 6;
  localparam int REG_W  = 2;
  localparam int DIV_STEPS = 32;
  localparam logic [PTS_W-1:0] PTS_RESET = 7'd64;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [REG_W-1:0] {
    REG_LOW  = 2'd0,
    REG_MID  = 2'd1,
    REG_HIGH = 2'd2
  } region_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'd0,
    S_RD0  = 4'd1,
    S_CHK0 = 4'd2,
    S_CHKN = 4'd3,
    S_SCAN = 4'd4,
    S_MUL  = 4'd5,
    S_DIVI = 4'd6,
    S_DIV  = 4'd7,
    S_FIN  = 4'd8,
    S_EMIT = 4'd9
  } step_t;

  typedef enum logic [3:0] {
    A_ACCEPT,
    A_ADDR_LAST,
    A_CHK_FIRST,
    A_CHK_LAST,
    A_SCAN,
    A_MUL,
    A_DIV_INIT,
    A_DIV_STEP,
    A_FIN,
    A_EMIT
  } act_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_QUERY,
    C_LE,
    C_GT,
    C_DIV_DONE,
    C_OUT_FREE
  } cond_t;

  // one control word: datapath action, branch test, branch target, and
  // whether a failed test holds the step (else falls through to the next)
  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t tgt;
    logic  hold;
  } ctrl_t;

  typedef struct packed {
    logic q_acc;
    logic le;
    logic gt;
    logic div_done;
    logic out_free;
  } stat_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = '{A_ACCEPT, C_QUERY, S_RD0, 1'b1};
    case (s)
      S_IDLE: c = '{A_ACCEPT,    C_QUERY,    S_RD0,  1'b1};
      S_RD0:  c = '{A_ADDR_LAST, C_ALWAYS,   S_CHK0, 1'b0};
      S_CHK0: c = '{A_CHK_FIRST, C_LE,       S_EMIT, 1'b0};
      S_CHKN: c = '{A_CHK_LAST,  C_GT,       S_EMIT, 1'b0};
      S_SCAN: c = '{A_SCAN,      C_LE,       S_MUL,  1'b1};
      S_MUL:  c = '{A_MUL,       C_ALWAYS,   S_DIVI, 1'b0};
      S_DIVI: c = '{A_DIV_INIT,  C_ALWAYS,   S_DIV,  1'b0};
      S_DIV:  c = '{A_DIV_STEP,  C_DIV_DONE, S_FIN,  1'b1};
      S_FIN:  c = '{A_FIN,       C_ALWAYS,   S_EMIT, 1'b0};
      S_EMIT: c = '{A_EMIT,      C_OUT_FREE, S_IDLE, 1'b1};
      default: c = '{A_ACCEPT,   C_QUERY,    S_RD0,  1'b1};
    endcase
    return c;
  endfunction

endpackage

[rtl/core/plti_seq.sv]
`timescale 1ns / 1ps

module plti_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  plti_pkg::stat_t stat,
  output plti_pkg::ctrl_t ctrl
);
  import plti_pkg::*;

  step_t step_r, step_nxt;
  logic  taken;

  always_comb begin
    ctrl = ucode(step_r);
  end

  always_comb begin
    case (ctrl.cond)
      C_ALWAYS:   taken = 1'b1;
      C_QUERY:    taken = stat.q_acc;
      C_LE:       taken = stat.le;
      C_GT:       taken = stat.gt;
      C_DIV_DONE: taken = stat.div_done;
      C_OUT_FREE: taken = stat.out_free;
      default:    taken = 1'b0;
    endcase
    if (taken) begin
      step_nxt = ctrl.tgt;
    end else if (ctrl.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_t'(step_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

[rtl/core/piecewise_linear_table_interp_unit.sv]
`timescale 1ns / 1ps
// channel  direction  handshake            payload
// in_      slave      in_tvalid/in_tready  tdata {point_y, point_x, entry_index}, tuser opcode
// out_     master     out_tvalid/out_tready tdata {segment, interp_value}, tuser region
// cfg_     write      cfg_we               cfg_wdata points_in_use
//
// A load beat is taken in the idle step and gives no result.
// A query at or below the first x stops after the first check, above the last x
// after the second; inside, it runs the one-entry-per-cycle table scan and the
// 32-step restoring divider before the result register loads.
// The next beat is accepted once the result register is loaded; the query
// holds in its last step while an earlier result waits on out_tready.
// Reset (synchronous, rst_n low) sets points_in_use to 64; the table is not cleared.

module piecewise_linear_table_interp_unit #(
  parameter int TABLE_DEPTH = plti_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // entry_index[5:0], point_x[37:6], point_y[69:38], zero pad
  input  logic [0:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // interp_value[31:0], segment[37:32], zero pad
  output logic [1:0]  out_tuser,  // region
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata   // points_in_use
);
  import plti_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  ctrl_t ctrl;
  stat_t stat;

  logic [2*VAL_W-1:0] mem [TABLE_DEPTH];
  logic [2*VAL_W-1:0] rd_r;
  logic [IDX_W-1:0]   addr_r;
  logic [IDX_W-1:0]   seg_r;
  logic [IDX_W-1:0]   last_idx;
  logic [PTS_W-1:0]   points_r;

  logic [VAL_W-1:0]   qx_r;
  logic [2*VAL_W-1:0] lo_r, hi_r;
  logic [2*VAL_W-1:0] prod_r;
  logic [VAL_W-1:0]   span_r, rem_r, quo_r, res_r;
  logic               neg_r;
  logic [4:0]         cnt_r;
  region_t            region_r;

  logic               out_tvalid_r;
  logic [VAL_W-1:0]   out_val_r;
  logic [SEG_W-1:0]   out_seg_r;
  region_t            out_reg_r;

  logic               in_acc;
  logic [IDX_IN_W-1:0] in_idx;
  logic [VAL_W-1:0]   in_x, in_y;
  logic [VAL_W-1:0]   rd_x, rd_y, lo_x, lo_y, hi_x, hi_y;
  logic [VAL_W:0]     dx_w, dy_w, span_w, mag_w;
  logic [2*VAL_W-1:0] prod_w;
  logic [VAL_W:0]     sh_w;
  logic [VAL_W+1:0]   diff_w;
  logic [31:0]        pts32, idx32;

  plti_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  assign in_idx = in_tdata[5:0];
  assign in_x   = in_tdata[37:6];
  assign in_y   = in_tdata[69:38];

  assign in_tready = (ctrl.act == A_ACCEPT);
  assign in_acc    = in_tvalid && in_tready;

  assign rd_x = rd_r[VAL_W-1:0];
  assign rd_y = rd_r[2*VAL_W-1:VAL_W];
  assign lo_x = lo_r[VAL_W-1:0];
  assign lo_y = lo_r[2*VAL_W-1:VAL_W];
  assign hi_x = hi_r[VAL_W-1:0];
  assign hi_y = hi_r[2*VAL_W-1:VAL_W];

  // last breakpoint in use: count clamped to [1, TABLE_DEPTH]
  assign pts32 = 32'(points_r);
  assign idx32 = 32'(in_idx);
  always_comb begin
    if (pts32 == 32'd0) begin
      last_idx = '0;
    end else if (pts32 > 32'(TABLE_DEPTH)) begin
      last_idx = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      last_idx = IDX_W'(pts32 - 32'd1);
    end
  end

  always_comb begin
    dx_w   = {qx_r[VAL_W-1], qx_r} - {lo_x[VAL_W-1], lo_x};
    dy_w   = {hi_y[VAL_W-1], hi_y} - {lo_y[VAL_W-1], lo_y};
    span_w = {hi_x[VAL_W-1], hi_x} - {lo_x[VAL_W-1], lo_x};
    mag_w  = dy_w[VAL_W] ? (~dy_w + (VAL_W+1)'(1)) : dy_w;
    prod_w = dx_w[VAL_W-1:0] * mag_w[VAL_W-1:0];
    sh_w   = {rem_r, quo_r[VAL_W-1]};
    diff_w = {1'b0, sh_w} - {2'b00, span_r};
  end

  assign stat.q_acc    = in_acc && (in_tuser[0] == OP_QUERY);
  assign stat.le       = $signed(qx_r) <= $signed(rd_x);
  assign stat.gt       = !stat.le;
  assign stat.div_done = (cnt_r == 5'(DIV_STEPS - 1));
  assign stat.out_free = !out_tvalid_r || out_tready;

  // table memory: write on an in-range load beat, registered read every cycle
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser[0] == OP_LOAD) && (idx32 < 32'(TABLE_DEPTH))) begin
      mem[IDX_W'(in_idx)] <= {in_y, in_x};
    end
    rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    case (ctrl.act)
      A_ACCEPT: begin
        qx_r   <= in_x;
        addr_r <= '0;
      end
      A_ADDR_LAST: begin
        addr_r <= last_idx;
      end
      A_CHK_FIRST: begin
        lo_r     <= rd_r;
        res_r    <= rd_y;
        region_r <= REG_LOW;
        seg_r    <= IDX_W'(1);
        addr_r   <= IDX_W'(1);
      end
      A_CHK_LAST: begin
        res_r    <= rd_y;
        region_r <= REG_HIGH;
        addr_r   <= addr_r + IDX_W'(1);
      end
      A_SCAN: begin
        region_r <= REG_MID;
        addr_r   <= addr_r + IDX_W'(1);
        if (stat.le) begin
          hi_r <= rd_r;
        end else begin
          lo_r  <= rd_r;
          seg_r <= seg_r + IDX_W'(1);
        end
      end
      A_MUL: begin
        prod_r <= prod_w;
        span_r <= span_w[VAL_W-1:0];
        neg_r  <= dy_w[VAL_W];
      end
      A_DIV_INIT: begin
        rem_r <= prod_r[2*VAL_W-1:VAL_W];
        quo_r <= prod_r[VAL_W-1:0];
        cnt_r <= '0;
      end
      A_DIV_STEP: begin
        cnt_r <= cnt_r + 5'd1;
        if (!diff_w[VAL_W+1]) begin
          rem_r <= diff_w[VAL_W-1:0];
          quo_r <= {quo_r[VAL_W-2:0], 1'b1};
        end else begin
          rem_r <= sh_w[VAL_W-1:0];
          quo_r <= {quo_r[VAL_W-2:0], 1'b0};
        end
      end
      A_FIN: begin
        res_r <= neg_r ? (lo_y - quo_r) : (lo_y + quo_r);
      end
      A_EMIT: begin
        if (stat.out_free) begin
          out_val_r <= res_r;
          out_reg_r <= region_r;
          out_seg_r <= (region_r == REG_MID) ? SEG_W'(seg_r) : '0;
        end
      end
      default: begin
        addr_r <= addr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      points_r     <= PTS_RESET;
    end else begin
      if (cfg_we) begin
        points_r <= cfg_wdata;
      end
      if (ctrl.act == A_EMIT && stat.out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_seg_r, out_val_r};
  assign out_tuser  = out_reg_r;

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.q_acc |=> !in_tready)
    else $error("query beat did not start the sequence");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0] == OP_LOAD) |=> in_tready)
    else $error("load beat did not return to idle");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.act == A_DIV_STEP) |-> (rem_r < span_r))
    else $error("divider remainder out of range");

  a_seg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != REG_MID) |-> (out_tdata[37:32] == '0))
    else $error("segment set outside interior region");

endmodule
